// File: rtl/fufr_pkg.sv
// ----------------------------------------------------------------------------
// fufr_pkg
// Shared constants, types and helpers for the H.264 RTP FU-A fragmenter.
// ----------------------------------------------------------------------------
package fufr_pkg;

    // Largest payload per RTP packet, in NAL bytes
    localparam logic [10:0] MAX_PAYLOAD   = 11'd1400;
    localparam int          MAX_FRAGMENTS = 64;
    // Largest NAL body (size minus header byte) that still fits
    localparam logic [16:0] MAX_BODY      = 17'(MAX_FRAGMENTS * int'(MAX_PAYLOAD));

    localparam logic [10:0] RTP_HDR_BYTES = 11'd12;
    localparam logic [10:0] FU_BYTES      = 11'd2;

    localparam logic [7:0]  NRI_MASK      = 8'h60;
    localparam logic [7:0]  TYPE_MASK     = 8'h1f;
    localparam logic [7:0]  FU_A_TYPE     = 8'h1c;
    localparam logic [7:0]  FU_START_BIT  = 8'h80;
    localparam logic [7:0]  FU_END_BIT    = 8'h40;

    localparam logic [4:0]  NAL_TYPE_SPS  = 5'd7;
    localparam logic [4:0]  NAL_TYPE_PPS  = 5'd8;

    // 90 kHz over 25 fps
    localparam logic [16:0] TS_INC_RESET  = 17'(90000 / 25);

    // Controller -> datapath
    typedef struct packed {
        logic load_single;   // emit single-NAL packet from input
        logic load_too_long; // emit the too-long flag result
        logic start_frag;    // capture input for fragmentation
        logic emit_frag;     // emit next fragment
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;      // output register can take a new item
        logic in_short;      // input fits one single-NAL packet
        logic in_too_long;   // input needs too many fragments
        logic frag_last;     // next fragment is the final one
    } t_dp_sts;

    function automatic logic is_param_set(input logic [7:0] hdr);
        logic [4:0] nal_type;
        nal_type = hdr[4:0];
        return (nal_type == NAL_TYPE_SPS) || (nal_type == NAL_TYPE_PPS);
    endfunction

endpackage

// File: rtl/h264_rtp_fu_a_fragmenter_top.sv
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_fragmenter_top
// H.264 RTP packetizer at descriptor level: one NAL in, packet items out.
// ----------------------------------------------------------------------------
// Each input item describes one NAL unit (header byte, size). A NAL shorter
// than 1400 bytes gives one single-NAL packet item. A larger NAL is split
// into FU-A fragments of at most 1400 body bytes, one item per cycle, after
// a setup step that captures the NAL; the walk subtracts 1400 from the
// remaining body bytes per fragment. A NAL needing over 64 fragments gives
// one item with too_long set and leaves sequence and timestamp alone. Output
// stall holds the walk in place. The 16-bit RTP sequence advances per packet;
// the 32-bit timestamp advances by ts_increment after every packetized NAL
// except SPS and PPS. The user must write ts_increment (reset 3600) through
// i_cfg_we / i_cfg_wdata while the block is idle; the block doesn't enforce it.
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_fragmenter_top import fufr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    // NAL descriptor items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_nal_header,
    input  logic [16:0] i_nal_size,
    // packet descriptor items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_frame_length,
    output logic [15:0] o_rtp_sequence,
    output logic [31:0] o_rtp_timestamp,
    output logic        o_fragmented,
    output logic [7:0]  o_fu_indicator,
    output logic [7:0]  o_fu_header,
    output logic [16:0] o_payload_offset,
    output logic [10:0] o_payload_length,
    output logic        o_last_packet,
    output logic        o_too_long
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer: idle / fragment walk
    fufr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // counters, fragment math and the output register
    fufr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_nal_header     (i_nal_header),
        .i_nal_size       (i_nal_size),
        .i_out_stall      (i_out_stall),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .o_frame_length   (o_frame_length),
        .o_rtp_sequence   (o_rtp_sequence),
        .o_rtp_timestamp  (o_rtp_timestamp),
        .o_fragmented     (o_fragmented),
        .o_fu_indicator   (o_fu_indicator),
        .o_fu_header      (o_fu_header),
        .o_payload_offset (o_payload_offset),
        .o_payload_length (o_payload_length),
        .o_last_packet    (o_last_packet),
        .o_too_long       (o_too_long)
    );

endmodule

// File: rtl/fufr_ctrl.sv
// ----------------------------------------------------------------------------
// fufr_ctrl
// Sequencer: accepts NAL descriptors and steps the datapath through fragments.
// ----------------------------------------------------------------------------
module fufr_ctrl import fufr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_FRAG
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    if (i_sts.in_short) begin
                        o_cmd.load_single = 1'b1;
                    end else if (i_sts.in_too_long) begin
                        o_cmd.load_too_long = 1'b1;
                    end else begin
                        o_cmd.start_frag = 1'b1;
                        n_state          = ST_FRAG;
                    end
                end
            end
            ST_FRAG: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_frag = 1'b1;
                    if (i_sts.frag_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/fufr_dp.sv
// ----------------------------------------------------------------------------
// fufr_dp
// Datapath: sequence/timestamp counters, fragment walk and output register.
// ----------------------------------------------------------------------------
module fufr_dp import fufr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic [7:0]  i_nal_header,
    input  logic [16:0] i_nal_size,
    input  logic        i_out_stall,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output logic        o_out_valid,
    output logic [10:0] o_frame_length,
    output logic [15:0] o_rtp_sequence,
    output logic [31:0] o_rtp_timestamp,
    output logic        o_fragmented,
    output logic [7:0]  o_fu_indicator,
    output logic [7:0]  o_fu_header,
    output logic [16:0] o_payload_offset,
    output logic [10:0] o_payload_length,
    output logic        o_last_packet,
    output logic        o_too_long
);

    logic [16:0] r_ts_inc;
    logic [15:0] r_seq;
    logic [31:0] r_ts;
    logic [7:0]  r_hdr;
    logic [16:0] r_remaining;  // body bytes not yet sent
    logic [16:0] r_offset;
    logic        r_first;
    logic        r_out_valid;

    logic [10:0] r_frame_length;
    logic [15:0] r_rtp_sequence;
    logic [31:0] r_rtp_timestamp;
    logic        r_fragmented;
    logic [7:0]  r_fu_indicator;
    logic [7:0]  r_fu_header;
    logic [16:0] r_payload_offset;
    logic [10:0] r_payload_length;
    logic        r_last_packet;
    logic        r_too_long;

    logic [16:0] w_body;
    logic        w_frag_last;
    logic [10:0] w_frag_len;
    logic [7:0]  w_fu_header;
    logic        w_load;

    assign w_body      = i_nal_size - 17'd1;
    assign w_frag_last = (r_remaining <= {6'd0, MAX_PAYLOAD});
    assign w_frag_len  = w_frag_last ? r_remaining[10:0] : MAX_PAYLOAD;
    // start bit wins over end bit on a one-fragment NAL
    assign w_fu_header = (r_hdr & TYPE_MASK)
                       | (r_first ? FU_START_BIT : (w_frag_last ? FU_END_BIT : 8'h00));
    assign w_load      = i_cmd.load_single | i_cmd.load_too_long | i_cmd.emit_frag;

    assign o_sts.out_free    = !r_out_valid || !i_out_stall;
    assign o_sts.in_short    = (i_nal_size < {6'd0, MAX_PAYLOAD});
    assign o_sts.in_too_long = (w_body > MAX_BODY);
    assign o_sts.frag_last   = w_frag_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts_inc    <= TS_INC_RESET;
            r_seq       <= '0;
            r_ts        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ts_inc <= i_cfg_wdata;
            end
            if (i_cmd.load_single || i_cmd.emit_frag) begin
                r_seq <= r_seq + 16'd1;
            end
            if (i_cmd.load_single && !is_param_set(i_nal_header)) begin
                r_ts <= r_ts + {15'd0, r_ts_inc};
            end else if (i_cmd.emit_frag && w_frag_last && !is_param_set(r_hdr)) begin
                r_ts <= r_ts + {15'd0, r_ts_inc};
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // fragment walk and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_frag) begin
            r_hdr       <= i_nal_header;
            r_remaining <= w_body;
            r_offset    <= 17'd1;
            r_first     <= 1'b1;
        end else if (i_cmd.emit_frag) begin
            r_remaining <= r_remaining - {6'd0, MAX_PAYLOAD};
            r_offset    <= r_offset + {6'd0, MAX_PAYLOAD};
            r_first     <= 1'b0;
        end

        if (i_cmd.load_single) begin
            r_frame_length   <= RTP_HDR_BYTES + i_nal_size[10:0];
            r_rtp_sequence   <= r_seq;
            r_rtp_timestamp  <= r_ts;
            r_fragmented     <= 1'b0;
            r_fu_indicator   <= 8'h00;
            r_fu_header      <= 8'h00;
            r_payload_offset <= '0;
            r_payload_length <= i_nal_size[10:0];
            r_last_packet    <= 1'b1;
            r_too_long       <= 1'b0;
        end else if (i_cmd.load_too_long) begin
            r_frame_length   <= '0;
            r_rtp_sequence   <= '0;
            r_rtp_timestamp  <= '0;
            r_fragmented     <= 1'b0;
            r_fu_indicator   <= 8'h00;
            r_fu_header      <= 8'h00;
            r_payload_offset <= '0;
            r_payload_length <= '0;
            r_last_packet    <= 1'b1;
            r_too_long       <= 1'b1;
        end else if (i_cmd.emit_frag) begin
            r_frame_length   <= RTP_HDR_BYTES + FU_BYTES + w_frag_len;
            r_rtp_sequence   <= r_seq;
            r_rtp_timestamp  <= r_ts;
            r_fragmented     <= 1'b1;
            r_fu_indicator   <= (r_hdr & NRI_MASK) | FU_A_TYPE;
            r_fu_header      <= w_fu_header;
            r_payload_offset <= r_offset;
            r_payload_length <= w_frag_len;
            r_last_packet    <= w_frag_last;
            r_too_long       <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_length   = r_frame_length;
    assign o_rtp_sequence   = r_rtp_sequence;
    assign o_rtp_timestamp  = r_rtp_timestamp;
    assign o_fragmented     = r_fragmented;
    assign o_fu_indicator   = r_fu_indicator;
    assign o_fu_header      = r_fu_header;
    assign o_payload_offset = r_payload_offset;
    assign o_payload_length = r_payload_length;
    assign o_last_packet    = r_last_packet;
    assign o_too_long       = r_too_long;

endmodule

// File: rtl/fufr_checker.sv
// ----------------------------------------------------------------------------
// fufr_checker
// Port-level checks for the fragmenter, bound to the top level.
// ----------------------------------------------------------------------------
module fufr_checker import fufr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [10:0] o_frame_length,
    input logic [15:0] o_rtp_sequence,
    input logic        o_fragmented,
    input logic [16:0] o_payload_offset,
    input logic [10:0] o_payload_length,
    input logic        o_last_packet,
    input logic        o_too_long
);

    // too-long flag ends the NAL and is never a fragment
    a_too_long_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_too_long) |-> (o_last_packet && !o_fragmented))
        else $error("too_long item not final or marked fragmented");

    // single-NAL packet is always the last of its NAL
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_fragmented) |-> o_last_packet)
        else $error("single-NAL item without last_packet");

    // fragment frame length = RTP header + FU bytes + payload
    a_frag_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fragmented)
            |-> (o_frame_length == RTP_HDR_BYTES + FU_BYTES + o_payload_length))
        else $error("fragment frame length mismatch");

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
            |=> (o_out_valid && $stable(o_rtp_sequence) && $stable(o_payload_offset)))
        else $error("stalled output item changed");

endmodule

bind h264_rtp_fu_a_fragmenter_top fufr_checker u_fufr_checker (.*);

// File: verif/fufr_packet_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fufr_packet_checker
// Watches both item channels and the config port of the FU-A fragmenter,
// predicts every packet item from accepted NAL items and compares in order.
// ----------------------------------------------------------------------------
module fufr_packet_checker import fufr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_nal_header,
    input  logic [16:0] i_nal_size,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [10:0] i_frame_length,
    input  logic [15:0] i_rtp_sequence,
    input  logic [31:0] i_rtp_timestamp,
    input  logic        i_fragmented,
    input  logic [7:0]  i_fu_indicator,
    input  logic [7:0]  i_fu_header,
    input  logic [16:0] i_payload_offset,
    input  logic [10:0] i_payload_length,
    input  logic        i_last_packet,
    input  logic        i_too_long,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [10:0] frame_length;
        logic [15:0] rtp_sequence;
        logic [31:0] rtp_timestamp;
        logic        fragmented;
        logic [7:0]  fu_indicator;
        logic [7:0]  fu_header;
        logic [16:0] payload_offset;
        logic [10:0] payload_length;
        logic        last_packet;
        logic        too_long;
    } t_pkt_desc;

    t_pkt_desc   expected_pkts[$];
    logic [15:0] seq_now;
    logic [31:0] ts_now;
    logic [16:0] ts_step;

    // Expands one NAL into its packet items and advances sequence/timestamp
    task automatic predict_packets(input logic [7:0] hdr, input logic [16:0] size);
        int unsigned body;
        int unsigned count;
        int unsigned tail;
        int unsigned len;
        t_pkt_desc   p;
        logic [4:0]  ntype;
        ntype = hdr[4:0];
        if (size < MAX_PAYLOAD) begin
            p = '0;
            p.frame_length   = RTP_HDR_BYTES + size[10:0];
            p.rtp_sequence   = seq_now;
            p.rtp_timestamp  = ts_now;
            p.payload_length = size[10:0];
            p.last_packet    = 1'b1;
            expected_pkts.push_back(p);
            seq_now = seq_now + 16'd1;
        end else begin
            body  = size - 1;
            count = body / int'(MAX_PAYLOAD);
            tail  = body % int'(MAX_PAYLOAD);
            if (tail != 0) count++;
            if (count > MAX_FRAGMENTS) begin
                // flag only, state untouched
                p = '0;
                p.last_packet = 1'b1;
                p.too_long    = 1'b1;
                expected_pkts.push_back(p);
                return;
            end
            for (int unsigned k = 0; k < count; k++) begin
                len = (k + 1 < count || tail == 0) ? int'(MAX_PAYLOAD) : tail;
                p = '0;
                p.frame_length   = 11'(RTP_HDR_BYTES + FU_BYTES + len);
                p.rtp_sequence   = seq_now;
                p.rtp_timestamp  = ts_now;
                p.fragmented     = 1'b1;
                p.fu_indicator   = (hdr & NRI_MASK) | FU_A_TYPE;
                p.fu_header      = hdr & TYPE_MASK;
                if (k == 0)
                    p.fu_header = p.fu_header | FU_START_BIT;
                else if (k + 1 == count)
                    p.fu_header = p.fu_header | FU_END_BIT;
                p.payload_offset = 17'(1 + k * int'(MAX_PAYLOAD));
                p.payload_length = 11'(len);
                p.last_packet    = (k + 1 == count);
                expected_pkts.push_back(p);
                seq_now = seq_now + 16'd1;
            end
        end
        if (ntype != NAL_TYPE_SPS && ntype != NAL_TYPE_PPS)
            ts_now = ts_now + {15'd0, ts_step};
    endtask

    function automatic int field_bad(input string name, input longint unsigned want,
                                     input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : watch
        t_pkt_desc want;
        int        bad;
        if (!i_rst_n) begin
            seq_now = '0;
            ts_now  = '0;
            ts_step = TS_INC_RESET;
            expected_pkts.delete();
        end else begin
            if (i_cfg_we)
                ts_step = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                predict_packets(i_nal_header, i_nal_size);
            if (i_out_valid && !i_out_stall) begin
                if (expected_pkts.size() == 0) begin
                    $error("packet item with nothing expected (seq %0d)", i_rtp_sequence);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = expected_pkts.pop_front();
                    bad  = field_bad("frame_length", want.frame_length, i_frame_length)
                         + field_bad("rtp_sequence", want.rtp_sequence, i_rtp_sequence)
                         + field_bad("rtp_timestamp", want.rtp_timestamp, i_rtp_timestamp)
                         + field_bad("fragmented", want.fragmented, i_fragmented)
                         + field_bad("fu_indicator", want.fu_indicator, i_fu_indicator)
                         + field_bad("fu_header", want.fu_header, i_fu_header)
                         + field_bad("payload_offset", want.payload_offset, i_payload_offset)
                         + field_bad("payload_length", want.payload_length, i_payload_length)
                         + field_bad("last_packet", want.last_packet, i_last_packet)
                         + field_bad("too_long", want.too_long, i_too_long);
                    o_mismatches = o_mismatches + bad;
                end
            end
        end
        o_pending <= expected_pkts.size();
    end

endmodule

// File: verif/h264_rtp_fu_a_fragmenter_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_fragmenter_top_tb
// Drives NAL descriptor items into the FU-A fragmenter and gives the verdict.
// ----------------------------------------------------------------------------
// A directed run covers size and header corners (empty NAL, largest single
// packet, one-fragment NALs, 64 fragments, too many fragments, SPS/PPS).
// Random phases follow, each with its own timestamp increment written while
// the block is drained, and with different sender gap / receiver stall
// rates. The checker instance predicts and compares every packet item.
// ----------------------------------------------------------------------------
module h264_rtp_fu_a_fragmenter_top_tb;
    import fufr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before giving up
    localparam int DRAIN_CYCLES    = 70;    // longer than a full unstalled fragment walk
    localparam int ITEMS_PER_PHASE = 45;
    localparam int INC_HIGH        = 90000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [16:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic [7:0]  nal_header = '0;
    logic [16:0] nal_size  = '0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [10:0] frame_length;
    logic [15:0] rtp_sequence;
    logic [31:0] rtp_timestamp;
    logic        fragmented;
    logic [7:0]  fu_indicator;
    logic [7:0]  fu_header;
    logic [16:0] payload_offset;
    logic [10:0] payload_length;
    logic        last_packet;
    logic        too_long;

    int          mismatches;
    int          pending;
    int          gap_pct   = 0;  // chance per cycle the sender holds off
    int          stall_pct = 0;  // chance per cycle the receiver stalls
    int          quiet_cycles = 0;

    always #6 clk = ~clk;

    h264_rtp_fu_a_fragmenter_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_nal_header     (nal_header),
        .i_nal_size       (nal_size),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_frame_length   (frame_length),
        .o_rtp_sequence   (rtp_sequence),
        .o_rtp_timestamp  (rtp_timestamp),
        .o_fragmented     (fragmented),
        .o_fu_indicator   (fu_indicator),
        .o_fu_header      (fu_header),
        .o_payload_offset (payload_offset),
        .o_payload_length (payload_length),
        .o_last_packet    (last_packet),
        .o_too_long       (too_long)
    );

    fufr_packet_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_nal_header     (nal_header),
        .i_nal_size       (nal_size),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_frame_length   (frame_length),
        .i_rtp_sequence   (rtp_sequence),
        .i_rtp_timestamp  (rtp_timestamp),
        .i_fragmented     (fragmented),
        .i_fu_indicator   (fu_indicator),
        .i_fu_header      (fu_header),
        .i_payload_offset (payload_offset),
        .i_payload_length (payload_length),
        .i_last_packet    (last_packet),
        .i_too_long       (too_long),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    // Receiver back-pressure: one fresh draw per cycle, rate set per phase
    always @(posedge clk) begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Watchdog: any cycle with no item moving on either channel counts
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one NAL item and hold it until accepted. A sender gap, when
    // drawn, drops valid first so idle cycles land between items.
    task automatic send_nal(input logic [7:0] hdr, input logic [16:0] size);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid   <= 1'b1;
        nal_header <= hdr;
        nal_size   <= size;
        do @(posedge clk); while (in_stall);
    endtask

    // Pending count is registered, so always wait for a clock edge before looking
    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    // Config write only with nothing in flight
    task automatic set_increment(input logic [16:0] value);
        in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random NALs: mostly single packets and short fragment runs, a few
    // longer runs up to the 64-fragment ceiling, some past it, and boundary sizes.
    task automatic send_random_nals(input int count);
        logic [7:0]  hdr;
        logic [16:0] size;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            hdr  = 8'($urandom_range(255));
            if ($urandom_range(4) == 0)
                hdr[4:0] = $urandom_range(1) ? NAL_TYPE_SPS : NAL_TYPE_PPS;
            if (pick < 50)
                size = 17'($urandom_range(1399, 0));
            else if (pick < 78)
                size = 17'($urandom_range(14001, 1400));
            else if (pick < 84)
                size = 17'($urandom_range(89601, 14002));
            else if (pick < 90) begin
                case ($urandom_range(4))
                    0:       size = 17'd1399;
                    1:       size = 17'd1400;
                    2:       size = 17'd1401;
                    3:       size = 17'd89601;
                    default: size = 17'd89602;
                endcase
            end else
                size = 17'($urandom_range(131071, 89602));
            send_nal(hdr, size);
        end
    endtask

    task automatic run_phase(input logic [16:0] inc, input int gap, input int stall);
        set_increment(inc);
        gap_pct   = gap;
        stall_pct = stall;
        send_random_nals(ITEMS_PER_PHASE);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, reset increment still in place
        send_nal(8'h65, 17'd1);       // one-byte NAL
        send_nal(8'h41, 17'd0);       // empty NAL, single packet of 0 bytes
        send_nal(8'h67, 17'd20);      // SPS: timestamp holds
        send_nal(8'h68, 17'd4);       // PPS: timestamp holds
        send_nal(8'h41, 17'd1399);    // largest single packet
        send_nal(8'h65, 17'd1400);    // one fragment, start bit only, short body
        send_nal(8'h25, 17'd1401);    // one full fragment, start bit only
        send_nal(8'hff, 17'd1402);    // two fragments, 1-byte tail
        send_nal(8'h41, 17'd2801);    // two full fragments
        send_nal(8'h61, 17'd89601);   // 64 fragments, the ceiling
        send_nal(8'h65, 17'd89602);   // one fragment too many
        send_nal(8'h00, 17'd131071);  // largest size field, too long
        send_nal(8'h80, 17'd5000);    // forbidden bit set, type 0
        send_nal(8'h7c, 17'd3000);    // FU-A type in header itself
        send_nal(8'h67, 17'd4000);    // fragmented SPS
        send_nal(8'h1f, 17'd100);     // type 31, NRI 0

        // Random phases: increment extremes first, then random values
        run_phase(17'(INC_HIGH), 0, 0);
        run_phase(17'd0, 75, 0);
        run_phase(17'($urandom_range(INC_HIGH)), 0, 75);
        run_phase(17'($urandom_range(INC_HIGH)), 8, 8);

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
